[src/vsd_pkg.sv]
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants for the prefix-length varint stream decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NEG_RECURSIVE = 2'd1,
    STATUS_NEG_TWO_BIT  = 2'd2
  } status_t;

  typedef logic [7:0]  byte_t;
  typedef logic [63:0] value_t;
  typedef logic [3:0]  len_t;

  // One decoded result as it moves from the decoder to the output register.
  typedef struct packed {
    value_t  decoded_value;
    len_t    encoded_length;
    status_t status;
  } result_t;

  // Input register contents handed to the decoder.
  typedef struct packed {
    logic  valid;
    byte_t data_byte;
  } in_stage_t;

  // Prefix masks and match patterns.
  localparam byte_t MASK_1 = 8'b1000_0000;
  localparam byte_t MASK_2 = 8'b1100_0000;
  localparam byte_t MASK_3 = 8'b1110_0000;
  localparam byte_t MASK_4 = 8'b1111_0000;
  localparam byte_t MASK_6 = 8'b1111_1100;
  localparam byte_t PAT_1  = 8'b0000_0000;
  localparam byte_t PAT_2  = 8'b1000_0000;
  localparam byte_t PAT_3  = 8'b1100_0000;
  localparam byte_t PAT_4  = 8'b1110_0000;
  localparam byte_t PAT_32 = 8'b1111_0000;
  localparam byte_t PAT_64 = 8'b1111_0100;
  localparam byte_t PAT_NR = 8'b1111_1000;
  localparam byte_t LOW_7  = 8'b0111_1111;
  localparam byte_t LOW_6  = 8'b0011_1111;
  localparam byte_t LOW_5  = 8'b0001_1111;
  localparam byte_t LOW_4  = 8'b0000_1111;

  localparam len_t LEN_1 = 4'd1;
  localparam len_t LEN_2 = 4'd2;
  localparam len_t LEN_3 = 4'd3;
  localparam len_t LEN_4 = 4'd4;
  localparam len_t LEN_5 = 4'd5;
  localparam len_t LEN_8 = 4'd8;
  localparam len_t LEN_9 = 4'd9;

endpackage

[src/vsd_byte_if.sv]
// ----------------------------------------------------------------------------
// vsd_byte_if
// Valid/ready channel carrying one byte of the encoded stream.
// ----------------------------------------------------------------------------
interface vsd_byte_if;
  import vsd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[src/vsd_result_if.sv]
// ----------------------------------------------------------------------------
// vsd_result_if
// Valid/ready channel carrying one decoded value with its length and status.
// ----------------------------------------------------------------------------
interface vsd_result_if;
  import vsd_pkg::*;

  logic    valid;
  logic    ready;
  value_t  decoded_value;
  len_t    encoded_length;
  status_t status;

  modport source (output valid, output decoded_value, output encoded_length,
                  output status, input ready);
  modport sink   (input valid, input decoded_value, input encoded_length,
                  input status, output ready);
endinterface

[src/vsd_in_reg.sv]
// ----------------------------------------------------------------------------
// vsd_in_reg
// Input register: captures one stream byte and holds it until the decoder
// consumes it.
// ----------------------------------------------------------------------------
module vsd_in_reg (
  input  logic                clk,
  input  logic                rst,
  vsd_byte_if.sink            byte_in,
  input  logic                advance,
  output vsd_pkg::in_stage_t  stage
);
  import vsd_pkg::*;

  logic  valid;
  byte_t data_byte;

  assign byte_in.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_in.ready) begin
      valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      data_byte <= byte_in.data_byte;
    end
  end

  assign stage.valid     = valid;
  assign stage.data_byte = data_byte;
endmodule

[src/vsd_decode.sv]
// ----------------------------------------------------------------------------
// vsd_decode
// Prefix decode and payload accumulation. Holds the per-value state and
// produces at most one result for each byte it consumes.
// ----------------------------------------------------------------------------
module vsd_decode (
  input  logic                clk,
  input  logic                rst,
  input  vsd_pkg::in_stage_t  stage,
  input  logic                out_can_take,
  output logic                advance,
  output logic                res_valid,
  output vsd_pkg::result_t    res
);
  import vsd_pkg::*;

  value_t accumulator;
  len_t   bytes_remaining;
  len_t   total_length;
  value_t accumulator_next;
  len_t   bytes_remaining_next;
  len_t   total_length_next;
  byte_t  b;
  value_t shifted;
  len_t   remaining_dec;

  assign b             = stage.data_byte;
  assign shifted       = {accumulator[55:0], b};
  assign remaining_dec = bytes_remaining - LEN_1;

  always_comb begin
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    total_length_next    = total_length;
    res_valid            = 1'b0;
    res.decoded_value    = '0;
    res.encoded_length   = '0;
    res.status           = STATUS_OK;
    if (bytes_remaining != '0) begin
      bytes_remaining_next = remaining_dec;
      if (remaining_dec == '0) begin
        res_valid          = 1'b1;
        res.decoded_value  = shifted;
        res.encoded_length = total_length;
        accumulator_next   = '0;
        total_length_next  = '0;
      end else begin
        accumulator_next = shifted;
      end
    end else if ((b & MASK_1) == PAT_1) begin
      res_valid          = 1'b1;
      res.decoded_value  = {56'd0, b & LOW_7};
      res.encoded_length = LEN_1;
    end else if ((b & MASK_2) == PAT_2) begin
      accumulator_next     = {56'd0, b & LOW_6};
      bytes_remaining_next = LEN_1;
      total_length_next    = LEN_2;
    end else if ((b & MASK_3) == PAT_3) begin
      accumulator_next     = {56'd0, b & LOW_5};
      bytes_remaining_next = LEN_2;
      total_length_next    = LEN_3;
    end else if ((b & MASK_4) == PAT_4) begin
      accumulator_next     = {56'd0, b & LOW_4};
      bytes_remaining_next = LEN_3;
      total_length_next    = LEN_4;
    end else if ((b & MASK_6) == PAT_32) begin
      accumulator_next     = '0;
      bytes_remaining_next = LEN_4;
      total_length_next    = LEN_5;
    end else if ((b & MASK_6) == PAT_64) begin
      accumulator_next     = '0;
      bytes_remaining_next = LEN_8;
      total_length_next    = LEN_9;
    end else if ((b & MASK_6) == PAT_NR) begin
      res_valid  = 1'b1;
      res.status = STATUS_NEG_RECURSIVE;
    end else begin
      res_valid  = 1'b1;
      res.status = STATUS_NEG_TWO_BIT;
    end
  end

  // A byte that yields no result never waits on the output side.
  assign advance = stage.valid && (!res_valid || out_can_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_remaining <= '0;
      total_length    <= '0;
    end else if (advance) begin
      accumulator     <= accumulator_next;
      bytes_remaining <= bytes_remaining_next;
      total_length    <= total_length_next;
    end
  end
endmodule

[src/vsd_out_reg.sv]
// ----------------------------------------------------------------------------
// vsd_out_reg
// Result register: holds one decoded result until the downstream side takes
// it, and frees itself in the same cycle it is drained.
// ----------------------------------------------------------------------------
module vsd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  vsd_pkg::result_t   res,
  output logic               can_take,
  vsd_result_if.source       result_out
);
  import vsd_pkg::*;

  logic    valid;
  result_t held;

  assign can_take = !valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      held <= res;
    end
  end

  assign result_out.valid          = valid;
  assign result_out.decoded_value  = held.decoded_value;
  assign result_out.encoded_length = held.encoded_length;
  assign result_out.status         = held.status;
endmodule

[src/varint_stream_decoder_top.sv]
// A result becomes valid on result_out after the byte that completes its value
// passes the input register, then the result register.
// Throughput: one byte per cycle, set by the single decode step between the
// two registers; ready falls only while a finished result is not taken.
// Reset (rst, synchronous): both registers empty, the next byte is a prefix.
// ----------------------------------------------------------------------------
// varint_stream_decoder_top
// Decodes a stream of prefix-length variable integers into values, lengths
// and status codes.
// ----------------------------------------------------------------------------
module varint_stream_decoder_top (
  input  logic          clk,
  input  logic          rst,
  vsd_byte_if.sink      byte_in,
  vsd_result_if.source  result_out
);
  import vsd_pkg::*;

  in_stage_t stage;
  result_t   res;
  logic      advance;
  logic      res_valid;
  logic      out_can_take;

  vsd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .advance (advance),
    .stage   (stage)
  );

  vsd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .out_can_take (out_can_take),
    .advance      (advance),
    .res_valid    (res_valid),
    .res          (res)
  );

  vsd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && res_valid),
    .res        (res),
    .can_take   (out_can_take),
    .result_out (result_out)
  );

  // A successful value always has a nonzero length; an error always has none.
  a_len_matches_status: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> ((result_out.status == STATUS_OK) ==
                          (result_out.encoded_length != '0)))
    else $error("length and status disagree");

  // Error results carry a zero value.
  a_error_value_zero: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.status != STATUS_OK) |->
      (result_out.decoded_value == '0))
    else $error("error result with nonzero value");

  // A held input byte is neither dropped nor overwritten while it waits.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && !advance) |=> (stage.valid && $stable(stage.data_byte)))
    else $error("input register lost a pending byte");

  // A result waiting downstream is not replaced.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.ready) |=>
      (result_out.valid && $stable(result_out.decoded_value)))
    else $error("pending result overwritten");
endmodule

[dv/tb_varint_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_varint_stream_decoder_top
// Self-checking bench for the varint stream decoder. A byte driver and a
// result monitor run as clocked processes. A predictor decodes every accepted
// byte on its own and queues the value, length and status that the block must
// return. The bench runs a directed byte stream first, then random streams of
// mostly well-formed values. Each phase uses its own source idling and sink
// stalling, and one phase holds the sink off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_varint_stream_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vsd_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 130;
  localparam int TAIL_CYCLES  = 8;

  typedef enum {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH_IDLE,
    PH_HOLD
  } phase_t;

  typedef enum {
    FORM_ONE,
    FORM_TWO,
    FORM_THREE,
    FORM_FOUR,
    FORM_U32,
    FORM_U64,
    FORM_NEG,
    FORM_NOISE
  } form_t;

  logic clk = 1'b0;
  logic rst;

  vsd_byte_if   byte_if ();
  vsd_result_if res_if ();

  varint_stream_decoder_top u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .result_out (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  phase_t  phase = PH_FREE;
  byte_t   pending_bytes[$];
  result_t expected_results[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      hold_count  = 0;

  // Decoder state as the predictor sees it.
  value_t  acc_q       = '0;
  len_t    remaining_q = '0;
  len_t    total_q     = '0;

  // Advances the predicted state by one byte. Returns 1 when the byte finishes
  // a value or is a rejected negative prefix.
  function automatic bit decode_byte(input byte_t b, output result_t r);
    r = '0;
    if (remaining_q != 0) begin
      acc_q       = {acc_q[55:0], b};
      remaining_q = remaining_q - 1'b1;
      if (remaining_q == 0) begin
        r.decoded_value  = acc_q;
        r.encoded_length = total_q;
        r.status         = STATUS_OK;
        acc_q            = '0;
        total_q          = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    if ((b & MASK_1) == PAT_1) begin
      r.decoded_value  = value_t'(b & LOW_7);
      r.encoded_length = LEN_1;
      r.status         = STATUS_OK;
      return 1'b1;
    end
    if ((b & MASK_2) == PAT_2) begin
      acc_q = value_t'(b & LOW_6);
      remaining_q = LEN_1;
      total_q = LEN_2;
      return 1'b0;
    end
    if ((b & MASK_3) == PAT_3) begin
      acc_q = value_t'(b & LOW_5);
      remaining_q = LEN_2;
      total_q = LEN_3;
      return 1'b0;
    end
    if ((b & MASK_4) == PAT_4) begin
      acc_q = value_t'(b & LOW_4);
      remaining_q = LEN_3;
      total_q = LEN_4;
      return 1'b0;
    end
    if ((b & MASK_6) == PAT_32) begin
      acc_q = '0;
      remaining_q = LEN_4;
      total_q = LEN_5;
      return 1'b0;
    end
    if ((b & MASK_6) == PAT_64) begin
      acc_q = '0;
      remaining_q = LEN_8;
      total_q = LEN_9;
      return 1'b0;
    end
    r.decoded_value  = '0;
    r.encoded_length = '0;
    r.status = ((b & MASK_6) == PAT_NR) ? STATUS_NEG_RECURSIVE : STATUS_NEG_TWO_BIT;
    return 1'b1;
  endfunction

  // Payload bytes lean toward the all-zero and all-one extremes.
  function automatic byte_t random_payload();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return byte_t'($urandom);
  endfunction

  // Appends one byte to the driver's queue.
  task automatic queue_byte(input byte_t b);
    pending_bytes = {pending_bytes, b};
  endtask

  // Queues one value of a random form, or a stray byte now and then.
  task automatic queue_random_value();
    int    pick;
    int    n_payload;
    form_t form;
    byte_t r;
    byte_t prefix;
    pick = $urandom_range(0, 99);
    r = byte_t'($urandom);
    if (pick < 25) form = FORM_ONE;
    else if (pick < 43) form = FORM_TWO;
    else if (pick < 58) form = FORM_THREE;
    else if (pick < 70) form = FORM_FOUR;
    else if (pick < 80) form = FORM_U32;
    else if (pick < 88) form = FORM_U64;
    else if (pick < 95) form = FORM_NEG;
    else form = FORM_NOISE;
    n_payload = 0;
    case (form)
      FORM_ONE: begin
        prefix = r & LOW_7;
      end
      FORM_TWO: begin
        prefix = PAT_2 | (r & LOW_6);
        n_payload = 1;
      end
      FORM_THREE: begin
        prefix = PAT_3 | (r & LOW_5);
        n_payload = 2;
      end
      FORM_FOUR: begin
        prefix = PAT_4 | (r & LOW_4);
        n_payload = 3;
      end
      FORM_U32: begin
        prefix = PAT_32 | (r & ~MASK_6);
        n_payload = 4;
      end
      FORM_U64: begin
        prefix = PAT_64 | (r & ~MASK_6);
        n_payload = 8;
      end
      FORM_NEG: begin
        prefix = PAT_NR | byte_t'(r[2:0]);
      end
      default: begin
        prefix = r;
      end
    endcase
    queue_byte(prefix);
    repeat (n_payload) queue_byte(random_payload());
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_if.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random_phase(input phase_t p);
    int queued;
    int before_size;
    phase = p;
    queued = 0;
    while (queued < PHASE_BYTES) begin
      before_size = pending_bytes.size();
      queue_random_value();
      queued += pending_bytes.size() - before_size;
    end
    wait_drained();
  endtask

  // Byte driver: when the current byte is taken or the channel is empty, the next
  // queued byte is loaded unless the phase's idle draw holds it off.
  always @(posedge clk) begin
    int idle_pct;
    case (phase)
      PH_SRC_IDLE:  idle_pct = 77;
      PH_BOTH_IDLE: idle_pct = 34;
      default:      idle_pct = 0;
    endcase
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || byte_if.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= pending_bytes.pop_front();
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Counts the cycles of the long sink hold.
  always @(posedge clk) begin
    if (!rst && phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
    end
  end

  // Sink ready. In the hold phase ready stays low long enough for the block
  // to fill and push back on the byte channel.
  always @(posedge clk) begin
    int stall_pct;
    case (phase)
      PH_SNK_STALL: stall_pct = 77;
      PH_BOTH_IDLE: stall_pct = 34;
      default:      stall_pct = 0;
    endcase
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Predictor: every accepted byte advances the model.
  always @(posedge clk) begin
    result_t predicted;
    bit      has_result;
    if (!rst && byte_if.valid && byte_if.ready) begin
      has_result = decode_byte(byte_if.data_byte, predicted);
      if (has_result) expected_results = {expected_results, predicted};
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %h length %0d status %0d", $time,
                 res_if.decoded_value, res_if.encoded_length, res_if.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_if.decoded_value !== want.decoded_value) begin
          $display("%0t: decoded_value expected %h actual %h", $time,
                   want.decoded_value, res_if.decoded_value);
          error_count++;
        end
        if (res_if.encoded_length !== want.encoded_length) begin
          $display("%0t: encoded_length expected %0d actual %0d", $time,
                   want.encoded_length, res_if.encoded_length);
          error_count++;
        end
        if (res_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, res_if.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    res_if.ready      = 1'b0;
    rst               = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: one-byte min/max; two-, four-byte, 64-bit max; 3-byte value;
    // a 32-bit read with top bit set that must not sign-extend; both negatives.
    phase = PH_FREE;
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_byte(8'hBF);
    queue_byte(8'hFF);
    queue_byte(8'hDF);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(8'hEF);
    repeat (3) queue_byte(8'hFF);
    queue_byte(8'hF3);
    queue_byte(8'h80);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(8'hF7);
    repeat (8) queue_byte(8'hFF);
    queue_byte(8'hF8);
    queue_byte(8'hFF);
    wait_drained();

    run_random_phase(PH_FREE);
    run_random_phase(PH_SRC_IDLE);
    run_random_phase(PH_SNK_STALL);
    run_random_phase(PH_BOTH_IDLE);
    run_random_phase(PH_HOLD);
    phase = PH_FREE;

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
